// ===== rtl/core/serial_loaded_bank_mapper_macros.svh =====
// Assertion macros shared by the bank mapper checkers.
// No dependencies; included by files that hold concurrent assertions.
`ifndef SERIAL_LOADED_BANK_MAPPER_MACROS_SVH
`define SERIAL_LOADED_BANK_MAPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SBLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sblm_pkg.sv =====
// Types and constants of the serial loaded bank mapper.
// No dependencies; imported by every module of the block.
package sblm_pkg;

  // Kind of bus access carried by one transaction
  typedef enum logic [1:0] {
    REQ_CPU_RD = 2'd0,
    REQ_CPU_WR = 2'd1,
    REQ_PPU_RD = 2'd2,
    REQ_PPU_WR = 2'd3
  } req_e;

  // Register picked by address bits 14:13 when the loader completes
  typedef enum logic [1:0] {
    TGT_CONTROL  = 2'd0,
    TGT_CHR_LOW  = 2'd1,
    TGT_CHR_HIGH = 2'd2,
    TGT_PRG      = 2'd3
  } tgt_e;

  // PRG banking mode, control bits 3:2
  typedef enum logic [1:0] {
    PRG_32K_A    = 2'd0,
    PRG_32K_B    = 2'd1,
    PRG_FIX_LOW  = 2'd2,
    PRG_FIX_HIGH = 2'd3
  } prg_mode_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_PRG_BANK_COUNT = 1'b0,
    CFG_CHR_BANK_COUNT = 1'b1
  } cfg_reg_e;

  localparam logic [4:0] CONTROL_RST    = 5'h1C;
  localparam logic [4:0] CONTROL_CLR_OR = 5'h0C;
  localparam logic [4:0] BANK_COUNT_RST = 5'd16;
  localparam logic [2:0] SRAM_REGION    = 3'b011;
  localparam logic [2:0] CHR_REGION     = 3'b000;
  localparam int unsigned LOAD_BITS     = 5;
  localparam int unsigned WRAM_AW       = 13;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] addr;
    logic [7:0]  write_data;
  } in_t;

  typedef struct packed {
    logic        handled;
    logic        to_sram;
    logic [17:0] xlat_addr;
    logic [7:0]  read_data;
    logic [1:0]  mirror_mode;
  } out_t;

  // Loader write request from the decoder
  typedef struct packed {
    logic       wr;
    logic       clear;
    logic       data_bit;
    logic [1:0] target;
  } ldr_req_t;

  // Current banking state seen by the translator
  typedef struct packed {
    logic [4:0] control;
    logic [4:0] chr_low;
    logic [4:0] chr_high;
    logic [4:0] chr_full;
    logic [2:0] prg_full;
    logic [3:0] prg_low;
    logic [3:0] prg_high;
    logic [4:0] chr_count;
    logic [1:0] mirror_next;
  } bank_t;

endpackage

// ===== rtl/core/sblm_regs.sv =====
// Serial loader, bank registers and configuration registers of the mapper.
// Depends on sblm_pkg.
module sblm_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  sblm_pkg::cfg_reg_e  cfg_index_i,
  input  logic [4:0]          cfg_data_i,
  input  sblm_pkg::ldr_req_t  ldr_i,
  output sblm_pkg::bank_t     bank_o
);
  import sblm_pkg::*;

  logic [4:0] prg_count_q, prg_count_d;
  logic [4:0] chr_count_q, chr_count_d;
  logic [4:0] control_q, control_d;
  logic [4:0] shift_q, shift_d;
  logic [2:0] count_q, count_d;
  logic [4:0] chr_low_q, chr_low_d;
  logic [4:0] chr_high_q, chr_high_d;
  logic [4:0] chr_full_q, chr_full_d;
  logic [2:0] prg_full_q, prg_full_d;
  logic [3:0] prg_low_q, prg_low_d;
  logic [3:0] prg_high_q, prg_high_d;
  logic [4:0] shift_new;
  logic [2:0] count_new;
  logic [4:0] cfg_last;
  logic [4:0] prg_last;

  assign shift_new = {ldr_i.data_bit, shift_q[4:1]};
  assign count_new = count_q + 3'd1;
  assign cfg_last  = cfg_data_i - 5'd1;
  assign prg_last  = prg_count_q - 5'd1;

  // Loader shifting, commit to target register, configuration writes
  always_comb begin
    prg_count_d = prg_count_q;
    chr_count_d = chr_count_q;
    control_d   = control_q;
    shift_d     = shift_q;
    count_d     = count_q;
    chr_low_d   = chr_low_q;
    chr_high_d  = chr_high_q;
    chr_full_d  = chr_full_q;
    prg_full_d  = prg_full_q;
    prg_low_d   = prg_low_q;
    prg_high_d  = prg_high_q;

    if (ldr_i.wr) begin
      if (ldr_i.clear) begin
        shift_d   = '0;
        count_d   = '0;
        control_d = control_q | CONTROL_CLR_OR;
      end else if (count_new >= 3'(LOAD_BITS)) begin
        shift_d = '0;
        count_d = '0;
        case (tgt_e'(ldr_i.target))
          TGT_CONTROL: begin
            control_d = shift_new;
          end
          TGT_CHR_LOW: begin
            if (control_q[4]) begin
              chr_low_d = shift_new;
            end else begin
              chr_full_d = {shift_new[4:1], 1'b0};
            end
          end
          TGT_CHR_HIGH: begin
            if (control_q[4]) begin
              chr_high_d = shift_new;
            end
          end
          TGT_PRG: begin
            case (prg_mode_e'(control_q[3:2]))
              PRG_FIX_LOW: begin
                prg_low_d  = '0;
                prg_high_d = shift_new[3:0];
              end
              PRG_FIX_HIGH: begin
                prg_low_d  = shift_new[3:0];
                prg_high_d = prg_last[3:0];
              end
              default: begin
                prg_full_d = shift_new[3:1];
              end
            endcase
          end
          default: begin
            control_d = control_q;
          end
        endcase
      end else begin
        shift_d = shift_new;
        count_d = count_new;
      end
    end

    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PRG_BANK_COUNT: begin
          prg_count_d = cfg_data_i;
          prg_high_d  = cfg_last[3:0];
        end
        CFG_CHR_BANK_COUNT: begin
          chr_count_d = cfg_data_i;
        end
        default: begin
          chr_count_d = chr_count_q;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q <= BANK_COUNT_RST;
      chr_count_q <= BANK_COUNT_RST;
      control_q   <= CONTROL_RST;
      shift_q     <= '0;
      count_q     <= '0;
      chr_low_q   <= '0;
      chr_high_q  <= '0;
      chr_full_q  <= '0;
      prg_full_q  <= '0;
      prg_low_q   <= '0;
      prg_high_q  <= 4'hF;
    end else begin
      prg_count_q <= prg_count_d;
      chr_count_q <= chr_count_d;
      control_q   <= control_d;
      shift_q     <= shift_d;
      count_q     <= count_d;
      chr_low_q   <= chr_low_d;
      chr_high_q  <= chr_high_d;
      chr_full_q  <= chr_full_d;
      prg_full_q  <= prg_full_d;
      prg_low_q   <= prg_low_d;
      prg_high_q  <= prg_high_d;
    end
  end

  assign bank_o.control     = control_q;
  assign bank_o.chr_low     = chr_low_q;
  assign bank_o.chr_high    = chr_high_q;
  assign bank_o.chr_full    = chr_full_q;
  assign bank_o.prg_full    = prg_full_q;
  assign bank_o.prg_low     = prg_low_q;
  assign bank_o.prg_high    = prg_high_q;
  assign bank_o.chr_count   = chr_count_q;
  assign bank_o.mirror_next = control_d[1:0];

endmodule

// ===== rtl/core/sblm_wram.sv =====
// 8 KB cartridge work RAM with a registered read port.
// Depends on sblm_pkg for the address width.
module sblm_wram (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic                         we_i,
  input  logic                         re_i,
  input  logic [sblm_pkg::WRAM_AW-1:0] addr_i,
  input  logic [7:0]                   wdata_i,
  output logic [7:0]                   rdata_o
);
  import sblm_pkg::*;

  logic [7:0] mem [2**WRAM_AW];
  logic [7:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Read port: zero for any transaction that is not a RAM read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= re_i ? mem[addr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/serial_loaded_bank_mapper.sv =====
// Top level of the serial loaded bank mapper: decode, translation, result register.
// Depends on sblm_pkg, sblm_regs and sblm_wram.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i) carries one bus access per
//    transaction: CPU read or write, PPU read or write.
//  - Output channel (out_valid_o / out_stall_i / out_data_o) returns exactly one
//    result per access, in order.
//  - Config channel (cfg_valid_i / cfg_ready_o) sets the PRG and CHR bank counts;
//    it is always ready; the user writes it while no access is in flight (not enforced).
//  - The result is registered: an access accepted in one cycle is shown in the next.
//  - Throughput is one access per cycle while no held result is stalled; the result
//    register and the work RAM read register are both loaded at the accept edge.
//  - When the receiver stalls with a result held, in_stall_o rises in the same cycle
//    and the held result stays unchanged until it is taken.
//  - Reset sets both bank counts to 16, control to 0x1C, the high PRG bank to 15 and
//    all other bank and loader state to zero. Work RAM contents are undefined until
//    written; there is no clearing pass.
module serial_loaded_bank_mapper (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sblm_pkg::in_t       in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sblm_pkg::out_t      out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  sblm_pkg::cfg_reg_e  cfg_index_i,
  input  logic [4:0]          cfg_data_i
);
  import sblm_pkg::*;

  logic       accept;
  logic       out_valid_q, out_valid_d;
  out_t       res_q, res_d;
  ldr_req_t   ldr;
  bank_t      bank;
  logic       is_sram;
  logic       ram_we;
  logic       ram_re;
  logic [7:0] ram_rdata;
  logic [3:0] prg_bank16;
  logic [4:0] chr_bank4;
  logic [15:0] a;

  assign a           = in_data_i.addr;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign is_sram     = (a[15:13] == SRAM_REGION);

  assign prg_bank16 = a[14] ? bank.prg_high : bank.prg_low;
  assign chr_bank4  = a[12] ? bank.chr_high : bank.chr_low;

  // Decode and address translation
  always_comb begin
    res_d             = '0;
    res_d.mirror_mode = bank.mirror_next;
    ldr               = '0;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    case (req_e'(in_data_i.req_type))
      REQ_CPU_RD: begin
        if (is_sram) begin
          res_d.handled = 1'b1;
          res_d.to_sram = 1'b1;
          ram_re        = 1'b1;
        end else if (a[15]) begin
          res_d.handled = 1'b1;
          if (bank.control[3]) begin
            res_d.xlat_addr = {prg_bank16, a[13:0]};
          end else begin
            res_d.xlat_addr = {bank.prg_full, a[14:0]};
          end
        end
      end
      REQ_CPU_WR: begin
        if (is_sram) begin
          res_d.handled = 1'b1;
          res_d.to_sram = 1'b1;
          ram_we        = accept;
        end else if (a[15]) begin
          ldr.wr       = accept;
          ldr.clear    = in_data_i.write_data[7];
          ldr.data_bit = in_data_i.write_data[0];
          ldr.target   = a[14:13];
        end
      end
      REQ_PPU_RD: begin
        if (a[15:13] == CHR_REGION) begin
          res_d.handled = 1'b1;
          if (bank.chr_count == '0) begin
            res_d.xlat_addr = {2'b00, a};
          end else if (bank.control[4]) begin
            res_d.xlat_addr = {1'b0, chr_bank4, a[11:0]};
          end else begin
            res_d.xlat_addr = {1'b0, bank.chr_full, 12'h000} + {5'd0, a[12:0]};
          end
        end
      end
      REQ_PPU_WR: begin
        if (a[15:13] == CHR_REGION) begin
          res_d.handled = 1'b1;
          if (bank.chr_count == '0) begin
            res_d.xlat_addr = {2'b00, a};
          end
        end
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  // Output register control
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  sblm_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ldr_i       (ldr),
    .bank_o      (bank)
  );

  sblm_wram u_wram (
    .clk_i   (clk_i),
    .en_i    (accept),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (a[WRAM_AW-1:0]),
    .wdata_i (in_data_i.write_data),
    .rdata_o (ram_rdata)
  );

  // RAM byte joins the registered fields
  always_comb begin
    out_data_o           = res_q;
    out_data_o.read_data = ram_rdata;
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/sblm_chk.sv =====
// Port-level checker for the serial loaded bank mapper, bound to the top level.
// Depends on sblm_pkg and serial_loaded_bank_mapper_macros.svh.
`include "serial_loaded_bank_mapper_macros.svh"

module sblm_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sblm_pkg::out_t      out_data_o
);
  import sblm_pkg::*;

  // Input stalls only while a result is held back by the receiver
  `SBLM_ASSERT_NOW(a_stall_cause, clk_i, rst_ni, in_stall_o,
                   out_valid_o && out_stall_i, "input stalled without a held result")

  // Every accepted transaction shows a result in the next cycle
  `SBLM_ASSERT_NEXT(a_one_cycle, clk_i, rst_ni, in_valid_i && !in_stall_o,
                    out_valid_o, "no result after accepted transaction")

  // Held result does not change
  `SBLM_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_data_o), "stalled result changed")

  // RAM traffic never carries a translated address; unclaimed accesses carry nothing
  `SBLM_ASSERT_NOW(a_sram_addr, clk_i, rst_ni, out_valid_o && out_data_o.to_sram,
                   out_data_o.handled && (out_data_o.xlat_addr == '0),
                   "work RAM result with address")

  `SBLM_ASSERT_NOW(a_unclaimed, clk_i, rst_ni, out_valid_o && !out_data_o.handled,
                   (out_data_o.xlat_addr == '0) && (out_data_o.read_data == '0) &&
                   !out_data_o.to_sram, "unclaimed access with payload")

endmodule

bind serial_loaded_bank_mapper sblm_chk u_sblm_chk (.*);
